// ----- hdl/bole_pkg.sv -----
// Shared types and constants for the bounded ordered list engine.
package bole_pkg;

   localparam int ACTION_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 8;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 7;
   localparam int DEPTH_DEFAULT = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INS_FRONT = 3'd0,
      ACT_INS_END   = 3'd1,
      ACT_INS_POS   = 3'd2,
      ACT_DELETE    = 3'd3,
      ACT_PRINT     = 3'd4,
      ACT_CLEAR     = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 3'd0,
      STATUS_FULL     = 3'd1,
      STATUS_BADPOS   = 3'd2,
      STATUS_NOTFOUND = 3'd3,
      STATUS_EMPTY    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_IDLE   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_ROTATE = 2'd3
   } cell_op_type;

   typedef enum logic {
      STATE_IDLE  = 1'b0,
      STATE_PRINT = 1'b1
   } state_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type               op;
      logic [COUNT_W-1:0]        idx;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

// ----- hdl/bole_req_if.sv -----
// Request channel: action, value and position with a valid/ready handshake.
interface bole_req_if;
   logic                                valid;
   logic                                ready;
   logic [bole_pkg::ACTION_W-1:0]       action;
   logic signed [bole_pkg::VALUE_W-1:0] value;
   logic [bole_pkg::POSITION_W-1:0]     position;

   modport source (output valid, action, value, position, input ready);
   modport sink   (input valid, action, value, position, output ready);
endinterface

// ----- hdl/bole_rsp_if.sv -----
// Response channel: status, entry value, entry count and last flag.
interface bole_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [bole_pkg::STATUS_W-1:0]       status;
   logic signed [bole_pkg::VALUE_W-1:0] entry_value;
   logic [bole_pkg::COUNT_W-1:0]        entry_count;
   logic                                last;

   modport source (output valid, status, entry_value, entry_count, last, input ready);
   modport sink   (input valid, status, entry_value, entry_count, last, output ready);
endinterface

// ----- hdl/bole_cell.sv -----
// One list slot: holds an entry and shifts, loads or compares on command.
module bole_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                                clock,
   input  bole_pkg::cell_cmd_type              cmd,
   input  logic signed [bole_pkg::VALUE_W-1:0] left_value,
   input  logic signed [bole_pkg::VALUE_W-1:0] right_value,
   input  logic signed [bole_pkg::VALUE_W-1:0] head_value,
   input  logic                                seen_in,
   output logic signed [bole_pkg::VALUE_W-1:0] value_out,
   output logic                                seen_out
);

   localparam logic [bole_pkg::COUNT_W-1:0] MY_IDX = bole_pkg::COUNT_W'(CELL_INDEX);

   logic signed [bole_pkg::VALUE_W-1:0] value_ff;
   logic signed [bole_pkg::VALUE_W-1:0] value_in;
   logic                                hit;

   // A match counts only inside the live part of the list
   assign hit = (cmd.op == bole_pkg::OP_DELETE) && (MY_IDX < cmd.idx) &&
                (value_ff == cmd.value);
   assign seen_out  = seen_in | hit;
   assign value_out = value_ff;

   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         bole_pkg::OP_INSERT: begin
            if (MY_IDX == cmd.idx) begin
               value_in = cmd.value;
            end else if (MY_IDX > cmd.idx) begin
               value_in = left_value;
            end
         end
         bole_pkg::OP_DELETE: begin
            // close the gap from the first match onwards
            if (seen_out) begin
               value_in = right_value;
            end
         end
         bole_pkg::OP_ROTATE: begin
            if (MY_IDX == cmd.idx) begin
               value_in = head_value;
            end else if (MY_IDX < cmd.idx) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ----- hdl/bole_chain.sv -----
// Row of list cells with neighbour links and the first-match ripple.
module bole_chain #(
   parameter int DEPTH = bole_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  bole_pkg::cell_cmd_type              cmd,
   output logic signed [bole_pkg::VALUE_W-1:0] head_value,
   output logic                                found
);

   logic signed [bole_pkg::VALUE_W-1:0] cell_value [DEPTH];
   logic                                seen       [DEPTH+1];

   assign seen[0]    = 1'b0;
   assign head_value = cell_value[0];
   assign found      = seen[DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [bole_pkg::VALUE_W-1:0] left_v;
      logic signed [bole_pkg::VALUE_W-1:0] right_v;

      if (g == 0) begin : g_first
         assign left_v = cmd.value;
      end else begin : g_inner_l
         assign left_v = cell_value[g-1];
      end

      if (g == DEPTH-1) begin : g_last
         assign right_v = cell_value[g];
      end else begin : g_inner_r
         assign right_v = cell_value[g+1];
      end

      bole_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .left_value  (left_v),
         .right_value (right_v),
         .head_value  (cell_value[0]),
         .seen_in     (seen[g]),
         .value_out   (cell_value[g]),
         .seen_out    (seen[g+1])
      );
   end

endmodule

// ----- hdl/bounded_ordered_list_engine.sv -----
// Top level of the bounded ordered list engine.
// Keeps an ordered list of up to DEPTH signed 32-bit values in a row of cells
// that shift, compare and rotate in parallel. Insert, delete, clear and
// unknown actions finish in the cycle they are accepted and give one response;
// a new request is taken every cycle as long as the response register is free
// or being drained. Print is accepted and then streams one entry a cycle by
// rotating the chain towards the head, while the response register is free or
// being drained; the request side stays busy until the last entry is sent.
// An empty print gives one response with status empty.
module bounded_ordered_list_engine #(
   parameter int DEPTH = bole_pkg::DEPTH_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   bole_req_if.sink        req_chan,
   bole_rsp_if.source      rsp_chan
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   bole_pkg::state_type    state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          pr_ff, pr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [bole_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic signed [bole_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic [bole_pkg::COUNT_W-1:0]        rcount_ff, rcount_in;
   logic                   last_ff, last_in;

   bole_pkg::cell_cmd_type cmd;
   bole_pkg::action_type   action;
   logic signed [bole_pkg::VALUE_W-1:0] head_value;
   logic                   found;
   logic                   accept;
   logic                   out_free;
   logic                   full;
   logic                   badpos;
   logic                   print_last;
   logic [bole_pkg::POSITION_W-1:0] pos_idx;
   logic [CW-1:0]          count_m1;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == bole_pkg::STATE_IDLE) && out_free;
   assign accept = req_chan.valid && req_chan.ready;
   assign action = bole_pkg::action_type'(req_chan.action);

   assign full     = (count_ff == FULL_COUNT);
   // positions 0, 1 and 2 all land after the first entry
   assign pos_idx  = (req_chan.position <= bole_pkg::POSITION_W'(2)) ?
                     bole_pkg::POSITION_W'(1) :
                     req_chan.position - bole_pkg::POSITION_W'(1);
   assign badpos   = bole_pkg::POSITION_W'(count_ff) < pos_idx;
   assign count_m1 = count_ff - CW'(1);
   assign print_last = (pr_ff == count_m1);

   // Cell command
   always_comb begin
      cmd.op    = bole_pkg::OP_IDLE;
      cmd.idx   = '0;
      cmd.value = req_chan.value;
      if (state_ff == bole_pkg::STATE_IDLE) begin
         if (accept) begin
            case (action)
               bole_pkg::ACT_INS_FRONT: begin
                  if (!full) begin
                     cmd.op = bole_pkg::OP_INSERT;
                  end
               end
               bole_pkg::ACT_INS_END: begin
                  if (!full) begin
                     cmd.op  = bole_pkg::OP_INSERT;
                     cmd.idx = bole_pkg::COUNT_W'(count_ff);
                  end
               end
               bole_pkg::ACT_INS_POS: begin
                  if (!full && !badpos) begin
                     cmd.op  = bole_pkg::OP_INSERT;
                     cmd.idx = pos_idx[bole_pkg::COUNT_W-1:0];
                  end
               end
               bole_pkg::ACT_DELETE: begin
                  cmd.op  = bole_pkg::OP_DELETE;
                  cmd.idx = bole_pkg::COUNT_W'(count_ff);
               end
               default: begin
                  cmd.op = bole_pkg::OP_IDLE;
               end
            endcase
         end
      end else if (out_free) begin
         cmd.op  = bole_pkg::OP_ROTATE;
         cmd.idx = bole_pkg::COUNT_W'(count_m1);
      end
   end

   bole_chain #(
      .DEPTH (DEPTH)
   ) u_chain (
      .clock      (clock),
      .cmd        (cmd),
      .head_value (head_value),
      .found      (found)
   );

   // Next state and response
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pr_in        = pr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      entry_in     = entry_ff;
      rcount_in    = rcount_ff;
      last_in      = last_ff;
      if (state_ff == bole_pkg::STATE_IDLE) begin
         if (accept) begin
            rsp_valid_in = 1'b1;
            status_in    = bole_pkg::STATUS_OK;
            entry_in     = '0;
            last_in      = 1'b1;
            case (action)
               bole_pkg::ACT_INS_FRONT, bole_pkg::ACT_INS_END: begin
                  if (full) begin
                     status_in = bole_pkg::STATUS_FULL;
                  end else begin
                     count_in = count_ff + CW'(1);
                  end
               end
               bole_pkg::ACT_INS_POS: begin
                  if (full) begin
                     status_in = bole_pkg::STATUS_FULL;
                  end else if (badpos) begin
                     status_in = bole_pkg::STATUS_BADPOS;
                  end else begin
                     count_in = count_ff + CW'(1);
                  end
               end
               bole_pkg::ACT_DELETE: begin
                  if (found) begin
                     count_in = count_m1;
                  end else begin
                     status_in = bole_pkg::STATUS_NOTFOUND;
                  end
               end
               bole_pkg::ACT_PRINT: begin
                  if (count_ff == '0) begin
                     status_in = bole_pkg::STATUS_EMPTY;
                  end else begin
                     // hold the response until the first entry is streamed
                     rsp_valid_in = 1'b0;
                     state_in     = bole_pkg::STATE_PRINT;
                     pr_in        = '0;
                  end
               end
               bole_pkg::ACT_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  status_in = bole_pkg::STATUS_OK;
               end
            endcase
            rcount_in = bole_pkg::COUNT_W'(count_in);
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b1;
         status_in    = bole_pkg::STATUS_OK;
         entry_in     = head_value;
         rcount_in    = bole_pkg::COUNT_W'(count_ff);
         last_in      = print_last;
         pr_in        = pr_ff + CW'(1);
         if (print_last) begin
            state_in = bole_pkg::STATE_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bole_pkg::STATE_IDLE;
         count_ff     <= '0;
         pr_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pr_ff        <= pr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      entry_ff  <= entry_in;
      rcount_ff <= rcount_in;
      last_ff   <= last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.entry_value = entry_ff;
   assign rsp_chan.entry_count = rcount_ff;
   assign rsp_chan.last        = last_ff;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the bounded ordered list engine.
module testbench;
   import bole_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 228;
   localparam int TAIL_ITEMS   = 40;
   localparam int PAUSE_AT     = 150;
   localparam int STALL_AT     = 100;
   localparam int STALL_CYCLES = 300;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int SETTLE       = 20;
   localparam int REPORT_MAX   = 10;
   localparam int N_ROWS       = 22;

   // Action codes the block treats as no-operations
   localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      status_type                status;
      logic signed [VALUE_W-1:0] entry_value;
      logic [COUNT_W-1:0]        entry_count;
      logic                      last;
   } list_rsp_type;

   typedef struct {
      logic [ACTION_W-1:0]       act;
      logic signed [VALUE_W-1:0] value;
      logic [POSITION_W-1:0]     position;
      int                        reps;
      logic                      typed;
      status_type                status;
      logic [COUNT_W-1:0]        count;
   } list_row_type;

   logic clock = 1'b0;
   logic reset;

   bole_req_if req_if ();
   bole_rsp_if rsp_if ();

   bounded_ordered_list_engine #(
      .DEPTH (DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted list contents and the responses still owed by the block
   logic signed [VALUE_W-1:0] list_model [DEPTH];
   int           list_len;
   list_rsp_type list_rsp_q [$];

   int  accepted_items;
   int  responses_checked;
   int  print_entries;
   int  mismatch_count;
   int  status_hits [5];
   bit  quiet_tail;
   int  cycle_no;
   int  rsp_gap_left;
   int  long_stall_left;
   bit  long_stall_done;

   // Directed rows; counts assume the default depth of sixteen
   list_row_type directed_rows [N_ROWS] = '{
      '{ACT_PRINT,     32'sd0,   8'd0,   1,         1'b1, STATUS_EMPTY,    7'd0},
      '{ACT_DELETE,    32'sd5,   8'd0,   1,         1'b1, STATUS_NOTFOUND, 7'd0},
      '{ACT_INS_POS,   32'sd7,   8'd0,   1,         1'b1, STATUS_BADPOS,   7'd0},
      '{ACT_INS_FRONT, VAL_MIN,  8'd0,   1,         1'b1, STATUS_OK,       7'd1},
      '{ACT_INS_POS,   32'sd1,   8'd1,   1,         1'b1, STATUS_OK,       7'd2},
      '{ACT_INS_END,   VAL_MAX,  8'd0,   1,         1'b1, STATUS_OK,       7'd3},
      '{ACT_INS_POS,   32'sd2,   8'd0,   1,         1'b1, STATUS_OK,       7'd4},
      '{ACT_INS_POS,   32'sd3,   8'd2,   1,         1'b1, STATUS_OK,       7'd5},
      '{ACT_INS_POS,   32'sd9,   8'd7,   1,         1'b1, STATUS_BADPOS,   7'd5},
      '{ACT_INS_POS,   -32'sd1,  8'd6,   1,         1'b1, STATUS_OK,       7'd6},
      '{ACT_INS_POS,   32'sd9,   8'd255, 1,         1'b1, STATUS_BADPOS,   7'd6},
      '{ACT_PRINT,     32'sd0,   8'd0,   1,         1'b0, STATUS_OK,       7'd0},
      '{ACT_DELETE,    32'sd3,   8'd0,   1,         1'b1, STATUS_OK,       7'd5},
      '{ACT_DELETE,    32'sd99,  8'd0,   1,         1'b1, STATUS_NOTFOUND, 7'd5},
      '{ACT_SPARE_6,   32'sd0,   8'd0,   1,         1'b1, STATUS_OK,       7'd5},
      '{ACT_SPARE_7,   -32'sd1,  8'd255, 1,         1'b1, STATUS_OK,       7'd5},
      '{ACT_INS_END,   32'sd100, 8'd0,   DEPTH - 5, 1'b0, STATUS_OK,       7'd0},
      '{ACT_INS_FRONT, 32'sd1,   8'd0,   1,         1'b1, STATUS_FULL,     7'(DEPTH)},
      '{ACT_INS_END,   32'sd1,   8'd0,   1,         1'b1, STATUS_FULL,     7'(DEPTH)},
      '{ACT_INS_POS,   32'sd1,   8'd255, 1,         1'b1, STATUS_FULL,     7'(DEPTH)},
      '{ACT_PRINT,     32'sd0,   8'd0,   1,         1'b0, STATUS_OK,       7'd0},
      '{ACT_CLEAR,     32'sd0,   8'd0,   1,         1'b1, STATUS_OK,       7'd0}
   };

   function automatic void owe_rsp(status_type st, logic signed [VALUE_W-1:0] entry,
                                   logic last);
      list_rsp_q.push_back('{st, entry, 7'(list_len), last});
      status_hits[st]++;
   endfunction

   // Apply one request to the predicted list and queue the responses it causes
   function automatic void apply_list_op(logic [ACTION_W-1:0] act,
                                         logic signed [VALUE_W-1:0] value,
                                         logic [POSITION_W-1:0] position);
      status_type st;
      int         ins_at;
      int         hit;
      st     = STATUS_OK;
      ins_at = -1;
      hit    = -1;
      case (act)
         ACT_INS_FRONT: begin
            if (list_len >= DEPTH) st = STATUS_FULL;
            else ins_at = 0;
         end
         ACT_INS_END: begin
            if (list_len >= DEPTH) st = STATUS_FULL;
            else ins_at = list_len;
         end
         ACT_INS_POS: begin
            // positions up to two all land in the second slot
            hit = (position <= 8'd2) ? 1 : int'(position) - 1;
            if (list_len >= DEPTH) st = STATUS_FULL;
            else if (list_len < hit) st = STATUS_BADPOS;
            else ins_at = hit;
         end
         ACT_DELETE: begin
            for (int i = list_len - 1; i >= 0; i--)
               if (list_model[i] == value) hit = i;
            if (hit < 0) begin
               st = STATUS_NOTFOUND;
            end else begin
               for (int i = hit; i + 1 < list_len; i++) list_model[i] = list_model[i + 1];
               list_len--;
            end
         end
         ACT_PRINT: begin
            if (list_len == 0) begin
               owe_rsp(STATUS_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < list_len; i++)
                  owe_rsp(STATUS_OK, list_model[i], i + 1 == list_len);
               print_entries += list_len;
            end
            return;
         end
         ACT_CLEAR: list_len = 0;
         default: ;
      endcase
      if (ins_at >= 0) begin
         for (int i = list_len; i > ins_at; i--) list_model[i] = list_model[i - 1];
         list_model[ins_at] = value;
         list_len++;
      end
      owe_rsp(st, '0, 1'b1);
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int spread;
      case ($urandom_range(0, 9))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2, 3, 4, 5: begin
            // small pool so that duplicate keys turn up
            spread = $urandom_range(0, 8);
            return spread - 4;
         end
         default: return $urandom;
      endcase
   endfunction

   // Call at a rising edge; returns at the edge that takes the transaction
   task automatic send_item(logic [ACTION_W-1:0] act, logic signed [VALUE_W-1:0] value,
                            logic [POSITION_W-1:0] position);
      req_if.valid    <= 1'b1;
      req_if.action   <= act;
      req_if.value    <= value;
      req_if.position <= position;
      do @(posedge clock); while (!req_if.ready);
      accepted_items++;
   endtask

   // Response side: random stalls, one long hold-off, none in the tail
   always @(posedge clock) begin
      logic next_ready;
      cycle_no++;
      if (!long_stall_done && accepted_items >= STALL_AT) begin
         long_stall_done = 1'b1;
         long_stall_left = STALL_CYCLES;
      end
      if (long_stall_left > 0) begin
         long_stall_left--;
         next_ready = 1'b0;
      end else if (quiet_tail || (cycle_no % 512) >= 384) begin
         next_ready = 1'b1;
      end else if (rsp_gap_left > 0) begin
         rsp_gap_left--;
         next_ready = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_gap_left = $urandom_range(1, 15) - 1;
         next_ready = 1'b0;
      end else begin
         next_ready = 1'b1;
      end
      rsp_if.ready <= next_ready;
   end

   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (list_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: response with none pending: status %0d value %0d count %0d last %0b",
                        $realtime, rsp_if.status, rsp_if.entry_value, rsp_if.entry_count,
                        rsp_if.last);
         end else begin
            want = list_rsp_q.pop_front();
            responses_checked++;
            if (rsp_if.status !== want.status || rsp_if.entry_value !== want.entry_value ||
                rsp_if.entry_count !== want.entry_count || rsp_if.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("%0t: response %0d differs", $realtime, responses_checked);
                  $display("   expected status %0d value %0d count %0d last %0b",
                           want.status, want.entry_value, want.entry_count, want.last);
                  $display("   actual   status %0d value %0d count %0d last %0b",
                           rsp_if.status, rsp_if.entry_value, rsp_if.entry_count, rsp_if.last);
               end
            end
         end
      end
   end

   initial begin
      list_row_type              row;
      logic [ACTION_W-1:0]       act;
      logic signed [VALUE_W-1:0] val;
      logic [POSITION_W-1:0]     pos;
      int                        pick;
      int                        drain_cycles;
      bit                        sender_quiet;

      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.action   <= ACT_INS_FRONT;
      req_if.value    <= '0;
      req_if.position <= '0;
      list_len = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         for (int k = 0; k < row.reps; k++) begin
            send_item(row.act, row.value + k, row.position);
            apply_list_op(row.act, row.value + k, row.position);
            if (row.typed) begin
               // swap in the hand-written response for this row
               void'(list_rsp_q.pop_back());
               list_rsp_q.push_back('{row.status, '0, row.count, 1'b1});
            end
         end
      end
      req_if.valid <= 1'b0;
      while (list_rsp_q.size() != 0) @(posedge clock);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet_tail   = n >= RANDOM_ITEMS - TAIL_ITEMS;
         sender_quiet = quiet_tail || (n / 32) % 3 == 2;
         if (n == PAUSE_AT) begin
            // hold until the block has handed back everything owed
            req_if.valid <= 1'b0;
            while (list_rsp_q.size() != 0) @(posedge clock);
         end else if (!sender_quiet && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         val  = pick_value();
         pos  = POSITION_W'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (pick < 22) begin
            act = ACT_INS_FRONT;
         end else if (pick < 44) begin
            act = ACT_INS_END;
         end else if (pick < 64) begin
            act = ACT_INS_POS;
            if ($urandom_range(0, 6) != 0)
               pos = POSITION_W'($urandom_range(0, list_len + 1));
         end else if (pick < 80) begin
            act = ACT_DELETE;
            if (list_len > 0 && $urandom_range(0, 3) != 0)
               val = list_model[$urandom_range(0, list_len - 1)];
         end else if (pick < 90) begin
            act = ACT_PRINT;
         end else if (pick < 95) begin
            act = ACT_CLEAR;
         end else begin
            act = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
         end
         send_item(act, val, pos);
         apply_list_op(act, val, pos);
      end
      req_if.valid <= 1'b0;

      drain_cycles = 0;
      while (list_rsp_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SETTLE) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses, %0d of them print entries",
               accepted_items, responses_checked, print_entries);
      $display("Refusals predicted: %0d full, %0d bad position, %0d key not found, %0d empty print",
               status_hits[STATUS_FULL], status_hits[STATUS_BADPOS],
               status_hits[STATUS_NOTFOUND], status_hits[STATUS_EMPTY]);
      if (list_rsp_q.size() != 0)
         $display("%0d responses never arrived", list_rsp_q.size());
      if (mismatch_count == 0 && list_rsp_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Timed out waiting for the engine");
      $display("Mismatches found");
      $finish;
   end

endmodule
